[rtl/ksh_pkg.sv]
// ----------------------------------------------------------------------------
// ksh_pkg
// Shared types and constants of the key string hash block.
// ----------------------------------------------------------------------------
package ksh_pkg;

    localparam int KEY_W   = 8;
    localparam int CHUNK_W = 16;
    localparam int ACC_W   = 29;
    localparam int INDEX_W = 16;

    // Position inside a key; code 3 is unused and behaves like POS_SKIP
    localparam logic [1:0] POS_SKIP = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_HIGH = 2'd2;

    localparam logic [KEY_W-1:0] TERM_NUL = 8'h00;
    localparam logic [KEY_W-1:0] TERM_GT  = 8'h3E;

    // Largest chunk: 255 + (255 << 7)
    localparam logic [CHUNK_W-1:0] CHUNK_MAX = 16'd32895;

    typedef logic [ACC_W-1:0] acc_t;

    function automatic logic is_term(input logic [KEY_W-1:0] b);
        is_term = (b == TERM_NUL) || (b == TERM_GT);
    endfunction

endpackage

[rtl/key_string_hash.sv]
// ----------------------------------------------------------------------------
// key_string_hash
// Bucket index of a key that arrives one byte per transfer.
// ----------------------------------------------------------------------------
// Takes one key byte per cycle while in_stall is low; the first byte of
// every key is dropped, and a byte of 0x00 or 0x3E after it ends the key.
// A finished key gives one hash_index transfer once its terminating byte
// has passed the chunk, square, m0, m1, m2 and output registers. The path
// is: chunk register, squaring multiplier, accumulator XOR, then a reciprocal
// multiply, a quotient-times-modulus multiply and a compare-subtract for the
// modulo. Each stage moves on as soon as the stage after it has room, so
// in_stall rises only when every stage holds an item behind a stalled output.
// ----------------------------------------------------------------------------
module key_string_hash
    import ksh_pkg::*;
#(
    parameter int HASH_MODULUS = 65519
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KEY_W-1:0]   key_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] hash_index
);

    localparam int Q_W  = ACC_W;
    localparam int R_W  = ACC_W + 1;
    localparam int MUL_W = ACC_W + Q_W;
    localparam logic [Q_W-1:0] MOD_RECIP =
        Q_W'((64'd1 << ACC_W) / HASH_MODULUS);
    localparam logic [R_W-1:0] MOD_R = R_W'(HASH_MODULUS);

    // Front key state
    logic [1:0]        pos_reg, pos_next;
    logic [KEY_W-1:0]  pend_reg, pend_next;

    // Chunk stage
    logic               c_valid_reg;
    logic               c_last_reg;
    logic [CHUNK_W-1:0] c_chunk_reg;

    // Square stage
    logic               s_valid_reg;
    logic               s_last_reg;
    acc_t               s_fold_reg;

    // Accumulator and modulo stages
    acc_t               acc_reg, acc_next;
    logic               m0_valid_reg;
    acc_t               m0_x_reg;
    logic               m1_valid_reg;
    acc_t               m1_x_reg;
    logic [Q_W-1:0]     m1_q_reg;
    logic               m2_valid_reg;
    acc_t               m2_x_reg;
    logic [R_W-1:0]     m2_qm_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic               accept;
    logic               term;
    logic               c_load;
    logic [CHUNK_W-1:0] chunk_in;
    logic               free_out, free_m2, free_m1, free_m0, free_s, free_c;
    logic [2*CHUNK_W-1:0] square;
    logic [MUL_W-1:0]   recip_prod;
    logic [Q_W+R_W-1:0] qm_prod;
    logic [R_W-1:0]     rem_raw;
    logic [R_W-1:0]     rem_fix;
    acc_t               acc_fold;

    // Room in each stage: empty, or its item moves on this cycle
    assign free_out = !out_valid_reg || !out_stall;
    assign free_m2  = !m2_valid_reg || free_out;
    assign free_m1  = !m1_valid_reg || free_m2;
    assign free_m0  = !m0_valid_reg || free_m1;
    assign free_s   = !s_valid_reg || !s_last_reg || free_m0;
    assign free_c   = !c_valid_reg || free_s;

    assign in_stall = !free_c;
    assign accept   = in_valid && free_c;
    assign term     = is_term(key_byte);

    always_comb
    begin
        pos_next  = pos_reg;
        pend_next = pend_reg;
        c_load    = 1'b0;
        chunk_in  = '0;
        if (accept)
        begin
            unique case (pos_reg)
                POS_LOW:
                begin
                    if (term)
                    begin
                        c_load    = 1'b1;
                        pos_next  = POS_SKIP;
                    end
                    else
                    begin
                        pend_next = key_byte;
                        pos_next  = POS_HIGH;
                    end
                end
                POS_HIGH:
                begin
                    c_load = 1'b1;
                    if (term)
                    begin
                        chunk_in = CHUNK_W'(pend_reg);
                        pos_next = POS_SKIP;
                    end
                    else
                    begin
                        chunk_in = CHUNK_W'(pend_reg) + {1'b0, key_byte, 7'd0};
                        pos_next = POS_LOW;
                    end
                    pend_next = '0;
                end
                default:
                begin
                    // drop the first byte of a key
                    pos_next = POS_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_SKIP;
            pend_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    // Chunk stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (free_c)
            c_valid_reg <= c_load;
    end

    always_ff @(posedge clk)
    begin
        if (free_c && c_load)
        begin
            c_chunk_reg <= chunk_in;
            c_last_reg  <= term;
        end
    end

    // Square stage
    assign square = c_chunk_reg * c_chunk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (free_s)
            s_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (free_s && c_valid_reg)
        begin
            s_fold_reg <= square[ACC_W+1:2];
            s_last_reg <= c_last_reg;
        end
    end

    // Accumulator: fold in, and clear once the key's total moves on
    assign acc_fold = acc_reg ^ s_fold_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (s_valid_reg && free_s)
            acc_next = s_last_reg ? '0 : acc_fold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            m0_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (free_m0)
                m0_valid_reg <= s_valid_reg && s_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_m0 && s_valid_reg && s_last_reg)
            m0_x_reg <= acc_fold;
    end

    // Quotient estimate: floor(x * floor(2^29 / M) / 2^29), low by at most one
    assign recip_prod = MUL_W'(m0_x_reg) * MUL_W'(MOD_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (free_m1)
            m1_valid_reg <= m0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (free_m1 && m0_valid_reg)
        begin
            m1_x_reg <= m0_x_reg;
            m1_q_reg <= recip_prod[MUL_W-1:ACC_W];
        end
    end

    // Quotient times modulus; only the low bits matter for the remainder
    assign qm_prod = (Q_W+R_W)'(m1_q_reg) * (Q_W+R_W)'(MOD_R);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else if (free_m2)
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (free_m2 && m1_valid_reg)
        begin
            m2_x_reg  <= m1_x_reg;
            m2_qm_reg <= qm_prod[R_W-1:0];
        end
    end

    // Remainder lands in [0, 2M): one correcting subtract
    assign rem_raw = {1'b0, m2_x_reg} - m2_qm_reg;
    assign rem_fix = (rem_raw >= MOD_R) ? (rem_raw - MOD_R) : rem_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (free_out)
            out_valid_reg <= m2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (free_out && m2_valid_reg)
            out_index_reg <= rem_fix[INDEX_W-1:0];
    end

    assign out_valid  = out_valid_reg;
    assign hash_index = out_index_reg;

    // Checks
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(hash_index) < 32'(HASH_MODULUS)))
        else $error("hash_index not below the modulus");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && s_last_reg && free_s) |=> (acc_reg == '0))
        else $error("accumulator not cleared after key end");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (c_valid_reg && s_valid_reg && s_last_reg && m0_valid_reg
                      && m1_valid_reg && m2_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (c_chunk_reg <= CHUNK_MAX))
        else $error("chunk out of range");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        m2_valid_reg |-> (rem_raw < (MOD_R << 1)))
        else $error("quotient estimate off by more than one");

endmodule

[dv/tb_key_string_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_string_hash
// Self-checking bench for the key string hash block: feeds key bytes as
// directed keys, random well-formed keys, noise and back-to-back bursts,
// predicts every bucket index from its own model of the chunk fold and
// checks each hash_index transfer in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_key_string_hash;
    import ksh_pkg::*;

    localparam int HASH_MODULUS = 65519;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 700;
    localparam int NOISE_ITEMS  = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [KEY_W-1:0]   key_byte;
    logic               out_valid;
    logic               out_stall;
    logic [INDEX_W-1:0] hash_index;

    // Predictor state
    logic [ACC_W-1:0]   fold_acc;
    logic [KEY_W-1:0]   low_byte;
    logic [1:0]         key_pos;

    logic [INDEX_W-1:0] owed_indexes[$];
    int                 errors;
    int                 items_sent;
    int                 cycle_count;
    bit                 quiet;

    key_string_hash #(
        .HASH_MODULUS (HASH_MODULUS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_byte   (key_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_index (hash_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("key_string_hash regression: fail");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void fold_chunk(input logic [31:0] chunk);
        logic [31:0] sq;
        sq = chunk * chunk;
        fold_acc = fold_acc ^ ACC_W'(sq >> 2);
    endfunction

    function automatic void hash_key_byte(input logic [KEY_W-1:0] b);
        bit term;
        term = (b == TERM_NUL) || (b == TERM_GT);
        if (key_pos == POS_LOW || key_pos == POS_HIGH)
        begin
            if (term)
            begin
                if (key_pos == POS_HIGH)
                    fold_chunk({24'd0, low_byte});
                owed_indexes.push_back(INDEX_W'(int'(fold_acc) % HASH_MODULUS));
                fold_acc = '0;
                low_byte = '0;
                key_pos  = POS_SKIP;
            end
            else if (key_pos == POS_LOW)
            begin
                low_byte = b;
                key_pos  = POS_HIGH;
            end
            else
            begin
                fold_chunk({24'd0, low_byte} + ({24'd0, b} << 7));
                low_byte = '0;
                key_pos  = POS_LOW;
            end
        end
        else
        begin
            // first byte of a key: drop it
            key_pos = POS_LOW;
        end
    endfunction

    function automatic logic [KEY_W-1:0] body_byte();
        logic [KEY_W-1:0] b;
        do
            b = KEY_W'($urandom_range(0, 255));
        while (b == TERM_NUL || b == TERM_GT);
        return b;
    endfunction

    // Enter and leave at a falling edge
    task automatic send_byte(input logic [KEY_W-1:0] b);
        int gap;
        gap = quiet ? 0 : idle_len();
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        key_byte = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hash_key_byte(b);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_key(input logic [KEY_W-1:0] first, input int body_len);
        send_byte(first);
        repeat (body_len) send_byte(body_byte());
        send_byte($urandom_range(0, 1) ? TERM_NUL : TERM_GT);
    endtask

    function automatic int key_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 95)
            return $urandom_range(7, 20);
        else
            return $urandom_range(21, 64);
    endfunction

    task automatic wait_drained();
        while (owed_indexes.size() != 0)
            @(negedge clk);
    endtask

    // Empty keys, terminators in the dropped slot, pair boundary, lone low
    // byte, largest chunk and the bytes next to the terminator codes
    task automatic test_directed();
        send_byte(8'h41);
        send_byte(TERM_NUL);
        send_byte(TERM_NUL);
        send_byte(TERM_GT);
        send_byte(TERM_GT);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(TERM_GT);
        send_byte(8'h6B);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(TERM_NUL);
        send_byte(8'h7A);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h3D);
        send_byte(8'h3F);
        send_byte(TERM_NUL);
    endtask

    task automatic test_random_keys();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            send_key(KEY_W'($urandom_range(0, 255)), key_len());
    endtask

    // Arbitrary bytes with terminators made common
    task automatic test_noise();
        int start;
        start = items_sent;
        while (items_sent - start < NOISE_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                send_byte($urandom_range(0, 1) ? TERM_NUL : TERM_GT);
            else
                send_byte(KEY_W'($urandom_range(0, 255)));
        end
    endtask

    // Hold the input until every owed index is out, then resume
    task automatic test_drain_pause();
        repeat (6) send_key(KEY_W'($urandom_range(0, 255)), key_len());
        wait_drained();
        repeat (6) send_key(KEY_W'($urandom_range(0, 255)), key_len());
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        repeat (12) send_key(KEY_W'($urandom_range(0, 255)), $urandom_range(0, 9));
        quiet = 1'b0;
    endtask

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = quiet ? 0 : idle_len();
            out_stall = (n != 0);
            if (n > 1)
                repeat (n - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_index
        logic [INDEX_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_indexes.size() == 0)
            begin
                $error("hash_index transfer with none owed: actual %0d", hash_index);
                errors++;
            end
            else
            begin
                want = owed_indexes.pop_front();
                if (hash_index !== want)
                begin
                    $error("hash_index mismatch: expected %0d, actual %0d", want, hash_index);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        key_byte    = '0;
        quiet       = 1'b0;
        errors      = 0;
        items_sent  = 0;
        cycle_count = 0;
        fold_acc    = '0;
        low_byte    = '0;
        key_pos     = POS_SKIP;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_drain_pause();
        test_back_to_back();
        test_random_keys();
        test_noise();
        test_back_to_back();
        test_random_keys();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("key_string_hash regression: pass");
        else
            $display("key_string_hash regression: fail");
        $finish;
    end

endmodule
